[rtl/assert_macros.svh]
// Assertion macros shared by the dispatcher RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold at every clock edge outside reset
`define EGD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Consequent that must hold in the cycle after the antecedent
`define EGD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/egd_pkg.sv]
// Shared types, codes and constants of the elevator group dispatcher
package egd_pkg;

   localparam int CARS_DEF   = 4;
   localparam int FLOORS_DEF = 64;
   localparam int QDEPTH_DEF = 2;

   localparam int MODE_W   = 3;
   localparam int CAR_FW   = 2;
   localparam int FLOOR_W  = 6;
   localparam int HEAD_W   = 2;
   localparam int CSR_W    = 3;
   localparam int KIND_W   = 3;
   localparam int GRP_BITS = 8;

   localparam logic [CSR_W-1:0] CARS_IN_USE_RST = 3'd4;

   // item modes
   localparam logic [MODE_W-1:0] MODE_HALL   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DEST   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ADV    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_PLACE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CANCEL = 3'd4;

   // car headings
   localparam logic [HEAD_W-1:0] HEAD_UP   = 2'd0;
   localparam logic [HEAD_W-1:0] HEAD_DOWN = 2'd1;
   localparam logic [HEAD_W-1:0] HEAD_IDLE = 2'd2;
   localparam logic [HEAD_W-1:0] HEAD_NONE = 2'd3;

   // command kinds after classification
   localparam logic [KIND_W-1:0] KIND_HALL   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DEST   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ADV    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PLACE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NOP    = 3'd5;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [CAR_FW-1:0]  car;
      logic [FLOOR_W-1:0] floor;
      logic [HEAD_W-1:0]  heading;
   } egd_req_type;

   typedef struct packed {
      logic               found;
      logic [CAR_FW-1:0]  chosen_car;
      logic [FLOOR_W-1:0] car_floor;
      logic [HEAD_W-1:0]  car_heading;
   } egd_rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CAR_FW-1:0]  car;
      logic [FLOOR_W-1:0] floor;
      logic [HEAD_W-1:0]  heading;
   } egd_cmd_type;

endpackage

[rtl/elevator_group_dispatcher.sv]
// Elevator group dispatcher top level: config register, front end, queue, sequencer
//
// Input channel req_*: one command per transfer (hall call, destination, advance,
// place, cancel). Result channel rsp_*: exactly one result per command, in order.
// Config channel csr_*: writes cars_in_use; always ready. Write it only while idle;
// the block does not enforce this. The front end classifies commands and clamps the floor into a short queue, so
// new commands are taken while the sequencer works or a result waits.
// Sequencer path: destination, place, cancel and an advance that only goes idle
// run EXEC, then REPORT; an advance that serves a stop adds GRP and BIT (two-step
// search over byte groups of the bitmap); a hall call scans N cars in SCAN, then
// runs EXEC if a car is found, else REPORT, N being cars_in_use capped at CARS (one
// car per cycle through the shared distance compare); unknown modes, a bad car index
// outside hall calls or N of zero go straight to REPORT, one command at a time.
// Reset is synchronous: all cars idle at floor 0 with no stops, cars_in_use 4,
// queue empty, no result pending.
// When rsp_ready is low the result holds in its output register; the sequencer
// waits before loading the next one, the queue fills and then req_ready drops.
module elevator_group_dispatcher import egd_pkg::*; #(
   parameter int CARS   = CARS_DEF,
   parameter int FLOORS = FLOORS_DEF,
   parameter int QDEPTH = QDEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  egd_req_type      req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output egd_rsp_type      rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data
);

   logic [CSR_W-1:0] cars_in_use_ff, cars_in_use_in;
   logic             q_full, q_push, q_pop, q_not_empty;
   egd_cmd_type      q_wdata, q_rdata;

   // configuration register
   assign csr_ready      = 1'b1;
   assign cars_in_use_in = (csr_valid && csr_ready) ? csr_data : cars_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cars_in_use_ff <= CARS_IN_USE_RST;
      end else begin
         cars_in_use_ff <= cars_in_use_in;
      end
   end

   egd_front #(
      .CARS   (CARS),
      .FLOORS (FLOORS)
   ) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wdata)
   );

   egd_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .not_empty (q_not_empty)
   );

   egd_back #(
      .CARS   (CARS),
      .FLOORS (FLOORS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cars_in_use (cars_in_use_ff),
      .q_valid     (q_not_empty),
      .q_data      (q_rdata),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

[rtl/egd_front.sv]
// Front end: accepts items, clamps the floor and classifies the command
module egd_front import egd_pkg::*; #(
   parameter int CARS   = CARS_DEF,
   parameter int FLOORS = FLOORS_DEF
) (
   input  logic        req_valid,
   output logic        req_ready,
   input  egd_req_type req_data,
   input  logic        q_full,
   output logic        q_push,
   output egd_cmd_type q_data
);

   logic car_ok;

   // transfer into the queue whenever it has room
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
   assign car_ok    = (32'(req_data.car) < 32'(CARS));

   always_comb begin
      q_data         = '0;
      q_data.car     = req_data.car;
      q_data.heading = req_data.heading;
      // floors past the top clamp to the top floor
      if (req_data.floor > FLOOR_W'(FLOORS - 1)) begin
         q_data.floor = FLOOR_W'(FLOORS - 1);
      end else begin
         q_data.floor = req_data.floor;
      end
      unique case (req_data.mode)
         MODE_HALL:   q_data.kind = KIND_HALL;
         MODE_DEST:   q_data.kind = car_ok ? KIND_DEST : KIND_NOP;
         MODE_ADV:    q_data.kind = car_ok ? KIND_ADV : KIND_NOP;
         MODE_PLACE:  q_data.kind = car_ok ? KIND_PLACE : KIND_NOP;
         MODE_CANCEL: q_data.kind = car_ok ? KIND_CANCEL : KIND_NOP;
         default:     q_data.kind = KIND_NOP;
      endcase
   end

endmodule

[rtl/egd_queue.sv]
// Short command queue between the front end and the car sequencer
`include "assert_macros.svh"
module egd_queue import egd_pkg::*; #(
   parameter int DEPTH = QDEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  egd_cmd_type push_data,
   output logic        full,
   input  logic        pop,
   output egd_cmd_type pop_data,
   output logic        not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   egd_cmd_type        entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   `EGD_ASSERT(a_no_pop_empty, pop |-> (count_ff != '0), "queue popped while empty")

endmodule

[rtl/egd_back.sv]
// Car sequencer: keeps car state, scans cars for hall calls, serves stops
`include "assert_macros.svh"
module egd_back import egd_pkg::*; #(
   parameter int CARS   = CARS_DEF,
   parameter int FLOORS = FLOORS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CSR_W-1:0] cars_in_use,
   input  logic             q_valid,
   input  egd_cmd_type      q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output egd_rsp_type      rsp_data
);

   localparam int CAR_W  = (CARS > 1) ? $clog2(CARS) : 1;
   localparam int CNT_W  = $clog2(CARS + 1);
   localparam int NW     = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int FIDX_W = $clog2(FLOORS);
   localparam int NGRP   = (FLOORS + GRP_BITS - 1) / GRP_BITS;
   localparam int GIDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int PAD_W  = NGRP * GRP_BITS;
   localparam int BIT_W  = $clog2(GRP_BITS);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
   localparam logic [ST_W-1:0] ST_SCAN   = 3'd1;
   localparam logic [ST_W-1:0] ST_EXEC   = 3'd2;
   localparam logic [ST_W-1:0] ST_GRP    = 3'd3;
   localparam logic [ST_W-1:0] ST_BIT    = 3'd4;
   localparam logic [ST_W-1:0] ST_REPORT = 3'd5;

   // car state
   logic [FLOOR_W-1:0] floors_ff [CARS];
   logic [FLOOR_W-1:0] floors_in [CARS];
   logic [HEAD_W-1:0]  heads_ff  [CARS];
   logic [HEAD_W-1:0]  heads_in  [CARS];
   logic [FLOORS-1:0]  up_ff     [CARS];
   logic [FLOORS-1:0]  up_in     [CARS];
   logic [FLOORS-1:0]  dn_ff     [CARS];
   logic [FLOORS-1:0]  dn_in     [CARS];

   // sequencer
   logic [ST_W-1:0]    state_ff, state_in;
   egd_cmd_type        cmd_ff, cmd_in;
   logic [CAR_W-1:0]   idx_ff, idx_in;
   logic [CAR_W-1:0]   win_ff, win_in;
   logic [CAR_W-1:0]   last_ff, last_in;
   logic [FLOOR_W-1:0] best_ff, best_in;
   logic               ok_ff, ok_in;
   logic               sel_up_ff, sel_up_in;
   logic [GIDX_W-1:0]  grp_ff, grp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   egd_rsp_type        rsp_ff, rsp_in;

   // current car view
   logic [FLOOR_W-1:0] cf, fl, span, new_floor;
   logic [HEAD_W-1:0]  ch, hd;
   logic [FLOORS-1:0]  us, ds, map_sel, fl_mask, clr_mask;
   logic [PAD_W-1:0]   pad;
   logic [GRP_BITS-1:0] grp_data [NGRP];
   logic [NGRP-1:0]    grp_nz;
   logic [GIDX_W-1:0]  grp_pick;
   logic [BIT_W-1:0]   bit_pick;
   logic [GRP_BITS-1:0] grp_word;
   logic [NW-1:0]      ciu_w, n_eff;
   logic [CAR_W-1:0]   n_last;
   logic               elig, better;

   assign cf = floors_ff[idx_ff];
   assign ch = heads_ff[idx_ff];
   assign us = up_ff[idx_ff];
   assign ds = dn_ff[idx_ff];
   assign fl = cmd_ff.floor;
   assign hd = cmd_ff.heading;

   // cars open to hall calls
   assign ciu_w  = NW'(cars_in_use);
   assign n_eff  = (ciu_w > NW'(CARS)) ? NW'(CARS) : ciu_w;
   assign n_last = CAR_W'(n_eff - NW'(1));

   // eligibility and distance of the scanned car
   assign elig = (ch == HEAD_IDLE)
              || (ch == HEAD_UP && hd == HEAD_UP && cf <= fl)
              || (ch == HEAD_DOWN && hd == HEAD_DOWN && cf >= fl);
   assign span   = (cf > fl) ? cf - fl : fl - cf;
   assign better = elig && (!ok_ff || span < best_ff);

   assign fl_mask = {{(FLOORS-1){1'b0}}, 1'b1} << fl[FIDX_W-1:0];

   // two-step stop search: pick a byte group, then a bit inside it
   assign map_sel = sel_up_ff ? us : ds;
   assign pad     = PAD_W'(map_sel);

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_data[g] = pad[g*GRP_BITS +: GRP_BITS];
         grp_nz[g]   = |pad[g*GRP_BITS +: GRP_BITS];
      end
   end

   always_comb begin
      grp_pick = '0;
      if (sel_up_ff) begin
         for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_nz[g]) grp_pick = GIDX_W'(g);
         end
      end else begin
         for (int g = 0; g < NGRP; g++) begin
            if (grp_nz[g]) grp_pick = GIDX_W'(g);
         end
      end
   end

   assign grp_word = grp_data[grp_ff];

   always_comb begin
      bit_pick = '0;
      if (sel_up_ff) begin
         for (int b = GRP_BITS - 1; b >= 0; b--) begin
            if (grp_word[b]) bit_pick = BIT_W'(b);
         end
      end else begin
         for (int b = 0; b < GRP_BITS; b++) begin
            if (grp_word[b]) bit_pick = BIT_W'(b);
         end
      end
   end

   assign new_floor = FLOOR_W'({grp_ff, bit_pick});
   assign clr_mask  = {{(FLOORS-1){1'b0}}, 1'b1} << new_floor[FIDX_W-1:0];

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      win_in       = win_ff;
      last_in      = last_ff;
      best_in      = best_ff;
      ok_in        = ok_ff;
      sel_up_in    = sel_up_ff;
      grp_in       = grp_ff;
      floors_in    = floors_ff;
      heads_in     = heads_ff;
      up_in        = up_ff;
      dn_in        = dn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               cmd_in  = q_data;
               ok_in   = 1'b0;
               best_in = '0;
               win_in  = '0;
               idx_in  = CAR_W'(q_data.car);
               unique case (q_data.kind) inside
                  KIND_HALL: begin
                     idx_in   = '0;
                     last_in  = n_last;
                     state_in = (n_eff == '0) ? ST_REPORT : ST_SCAN;
                  end
                  KIND_DEST, KIND_ADV, KIND_PLACE, KIND_CANCEL: begin
                     ok_in    = 1'b1;
                     state_in = ST_EXEC;
                  end
                  default: state_in = ST_REPORT;
               endcase
            end
         end

         // one car per cycle, nearest eligible wins, lowest index on ties
         ST_SCAN: begin
            if (better) begin
               ok_in   = 1'b1;
               best_in = span;
               win_in  = idx_ff;
            end
            if (idx_ff == last_ff) begin
               idx_in   = better ? idx_ff : win_ff;
               state_in = (ok_ff || better) ? ST_EXEC : ST_REPORT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_EXEC: begin
            state_in = ST_REPORT;
            unique case (cmd_ff.kind) inside
               KIND_HALL, KIND_DEST: begin
                  if (cf > fl) begin
                     dn_in[idx_ff] = ds | fl_mask;
                  end else begin
                     up_in[idx_ff] = us | fl_mask;
                  end
               end
               KIND_PLACE: begin
                  floors_in[idx_ff] = fl;
                  heads_in[idx_ff]  = (hd == HEAD_NONE) ? HEAD_IDLE : hd;
               end
               KIND_CANCEL: begin
                  up_in[idx_ff] = us & ~fl_mask;
                  dn_in[idx_ff] = ds & ~fl_mask;
               end
               KIND_ADV: begin
                  if (ch == HEAD_UP) begin
                     if (us != '0) begin
                        sel_up_in = 1'b1;
                        state_in  = ST_GRP;
                     end else if (ds != '0) begin
                        heads_in[idx_ff] = HEAD_DOWN;
                        sel_up_in        = 1'b0;
                        state_in         = ST_GRP;
                     end else begin
                        heads_in[idx_ff] = HEAD_IDLE;
                     end
                  end else begin
                     if (ds != '0) begin
                        sel_up_in = 1'b0;
                        state_in  = ST_GRP;
                     end else if (us != '0) begin
                        heads_in[idx_ff] = HEAD_UP;
                        sel_up_in        = 1'b1;
                        state_in         = ST_GRP;
                     end else begin
                        heads_in[idx_ff] = HEAD_IDLE;
                     end
                  end
               end
               default: state_in = ST_REPORT;
            endcase
         end

         ST_GRP: begin
            grp_in   = grp_pick;
            state_in = ST_BIT;
         end

         // move the car to the found stop and clear it
         ST_BIT: begin
            floors_in[idx_ff] = new_floor;
            if (sel_up_ff) begin
               up_in[idx_ff] = us & ~clr_mask;
            end else begin
               dn_in[idx_ff] = ds & ~clr_mask;
            end
            state_in = ST_REPORT;
         end

         // load the output register once it is free
         ST_REPORT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (ok_ff) begin
                  rsp_in.found       = 1'b1;
                  rsp_in.chosen_car  = CAR_FW'(idx_ff);
                  rsp_in.car_floor   = cf;
                  rsp_in.car_heading = ch;
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control and car state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CARS; c++) begin
            floors_ff[c] <= '0;
            heads_ff[c]  <= HEAD_IDLE;
            up_ff[c]     <= '0;
            dn_ff[c]     <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         floors_ff    <= floors_in;
         heads_ff     <= heads_in;
         up_ff        <= up_in;
         dn_ff        <= dn_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      idx_ff    <= idx_in;
      win_ff    <= win_in;
      last_ff   <= last_in;
      best_ff   <= best_in;
      ok_ff     <= ok_in;
      sel_up_ff <= sel_up_in;
      grp_ff    <= grp_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `EGD_ASSERT(a_miss_zero, (rsp_valid_ff && !rsp_ff.found) |-> (rsp_ff == '0), "miss with data")
   `EGD_ASSERT(a_search_nonempty, (state_ff == ST_GRP) |-> (map_sel != '0), "empty stop search")
   `EGD_ASSERT_NEXT(a_grp_then_bit, state_ff == ST_GRP, state_ff == ST_BIT, "group without bit")

endmodule
